### rtl/tlr_pkg.sv
// Shared types and constants for the thick line rasterizer.
// No dependencies; compiled first.

package tlr_pkg;

    // Field widths of the command and point beats
    localparam int COORD_W     = 16;
    localparam int BRUSH_W     = 12;
    localparam int COLOR_W     = 32;
    localparam int RECT_POS_W  = 12;
    localparam int RECT_SIZE_W = 9;

    // Internal coordinate and size widths (-2048..2048, 1..256)
    localparam int PIX_W   = 13;
    localparam int STAMP_W = 9;
    localparam int DELTA_W = 13;
    localparam int ERR_W   = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_DATA_W-1:0] SCREEN_W_RST = 13'd640;
    localparam logic [CFG_DATA_W-1:0] SCREEN_H_RST = 13'd480;
    localparam logic [CFG_DATA_W-1:0] SCREEN_MAX   = 13'd4096;

    // Opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Default fraction bits of the coordinate inputs
    localparam int COORD_FRAC_BITS_DEF = 4;

    // Command after rounding, held in the input register
    typedef struct packed {
        logic                      opcode;
        logic signed [PIX_W-1:0]   x1;
        logic signed [PIX_W-1:0]   y1;
        logic signed [PIX_W-1:0]   x2;
        logic signed [PIX_W-1:0]   y2;
        logic                      step_x_neg;
        logic                      step_y_neg;
        logic [DELTA_W-1:0]        dx;
        logic signed [DELTA_W:0]   dy_neg;
        logic [STAMP_W-1:0]        stamp;
        logic [COLOR_W-1:0]        color;
    } t_cmd;

    // One point beat
    typedef struct packed {
        logic                   point_valid;
        logic                   visible;
        logic [RECT_POS_W-1:0]  rect_x;
        logic [RECT_POS_W-1:0]  rect_y;
        logic [RECT_SIZE_W-1:0] rect_w;
        logic [RECT_SIZE_W-1:0] rect_h;
        logic [COLOR_W-1:0]     out_color;
        logic                   last;
    } t_point;

endpackage

### rtl/tlr_line_if.sv
// Command channel of the thick line rasterizer: valid/ready plus command fields.
// Depends on tlr_pkg for field widths.

interface tlr_line_if;
    logic                               valid;
    logic                               ready;
    logic                               opcode;
    logic signed [tlr_pkg::COORD_W-1:0] start_x;
    logic signed [tlr_pkg::COORD_W-1:0] start_y;
    logic signed [tlr_pkg::COORD_W-1:0] end_x;
    logic signed [tlr_pkg::COORD_W-1:0] end_y;
    logic [tlr_pkg::BRUSH_W-1:0]        brush_size;
    logic [tlr_pkg::COLOR_W-1:0]        pixel_color;

    modport source (
        output valid, opcode, start_x, start_y, end_x, end_y, brush_size, pixel_color,
        input  ready
    );
    modport sink (
        input  valid, opcode, start_x, start_y, end_x, end_y, brush_size, pixel_color,
        output ready
    );
endinterface

### rtl/tlr_point_if.sv
// Point channel of the thick line rasterizer: valid/ready plus stamp rectangle.
// Depends on tlr_pkg for field widths.

interface tlr_point_if;
    logic                              valid;
    logic                              ready;
    logic                              point_valid;
    logic                              visible;
    logic [tlr_pkg::RECT_POS_W-1:0]    rect_x;
    logic [tlr_pkg::RECT_POS_W-1:0]    rect_y;
    logic [tlr_pkg::RECT_SIZE_W-1:0]   rect_w;
    logic [tlr_pkg::RECT_SIZE_W-1:0]   rect_h;
    logic [tlr_pkg::COLOR_W-1:0]       out_color;
    logic                              last;

    modport source (
        output valid, point_valid, visible, rect_x, rect_y, rect_w, rect_h, out_color, last,
        input  ready
    );
    modport sink (
        input  valid, point_valid, visible, rect_x, rect_y, rect_w, rect_h, out_color, last,
        output ready
    );
endinterface

### rtl/thick_line_rasterizer.sv
// Thick line rasterizer top level: Bresenham stepping with a square brush.
// Depends on tlr_pkg, tlr_line_if and tlr_point_if.
//
// Usage:
//   i_line  carries command beats. A start beat (opcode 0) loads the two
//           endpoints (signed fixed point) and the brush size, and yields the
//           first point. A step beat (opcode 1) yields the next point.
//   o_point carries one beat per command: the clipped stamp rectangle, the
//           visible flag, the line color and a last flag on the end point.
//           A step with no line in progress gives a beat with point_valid 0.
//   i_cfg_* writes screen width (index 0) and height (index 1); write only
//           while no command is in flight.
// Path: the input register loads at the command accept edge; the result
// register loads from it once o_point is free (empty or taken).
// Throughput: one command per cycle while o_point is not held, set by the
// combinational Bresenham update and clip between the two registers.
// Reset: no line in progress, screen 640 x 480, both registers empty.
// Stall: while o_point is held, one more command is taken into the input
// register; ready then drops until the point beat is taken.

module thick_line_rasterizer #(
    parameter int COORD_FRAC_BITS = tlr_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tlr_line_if.sink                            i_line,
    tlr_point_if.source                         o_point,
    input  logic                                i_cfg_we,
    input  logic [tlr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tlr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int PW   = tlr_pkg::PIX_W;
    localparam int EW   = tlr_pkg::ERR_W;
    localparam int CW   = 15;                          // clip arithmetic width
    localparam int HALF = (1 << COORD_FRAC_BITS) >> 1;

    // ------------------------------------------------------------------
    // Rounding helpers: half away from zero, then saturate
    // ------------------------------------------------------------------
    function automatic logic signed [PW-1:0] round_coord(
        input logic signed [tlr_pkg::COORD_W-1:0] raw
    );
        logic signed [tlr_pkg::COORD_W:0] ext;
        logic [tlr_pkg::COORD_W:0]        mag;
        logic [tlr_pkg::COORD_W:0]        rnd;
        logic [PW-1:0]                    lim;
        ext = {raw[tlr_pkg::COORD_W-1], raw};
        mag = ext[tlr_pkg::COORD_W] ? (tlr_pkg::COORD_W+1)'(-ext)
                                    : (tlr_pkg::COORD_W+1)'(ext);
        rnd = (mag + (tlr_pkg::COORD_W+1)'(HALF)) >> COORD_FRAC_BITS;
        lim = (rnd > (tlr_pkg::COORD_W+1)'(2048)) ? PW'(2048) : rnd[PW-1:0];
        return ext[tlr_pkg::COORD_W] ? PW'(-$signed(lim)) : $signed(lim);
    endfunction

    function automatic logic [tlr_pkg::STAMP_W-1:0] round_brush(
        input logic [tlr_pkg::BRUSH_W-1:0] raw
    );
        logic [tlr_pkg::BRUSH_W:0] rnd;
        rnd = ({1'b0, raw} + (tlr_pkg::BRUSH_W+1)'(HALF)) >> COORD_FRAC_BITS;
        if (rnd == '0) begin
            return tlr_pkg::STAMP_W'(1);
        end else if (rnd > (tlr_pkg::BRUSH_W+1)'(256)) begin
            return tlr_pkg::STAMP_W'(256);
        end
        return rnd[tlr_pkg::STAMP_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic            r_s0_valid;
    tlr_pkg::t_cmd   r_s0;
    tlr_pkg::t_cmd   n_s0;
    logic            r_out_valid;
    tlr_pkg::t_point r_out;
    tlr_pkg::t_point n_out;
    logic            out_free;
    logic            s0_adv;
    logic            in_acc;

    assign out_free     = !r_out_valid || o_point.ready;
    assign s0_adv       = r_s0_valid && out_free;
    assign i_line.ready = !r_s0_valid || out_free;
    assign in_acc       = i_line.valid && i_line.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s0_valid  <= in_acc || (r_s0_valid && !out_free);
            r_out_valid <= s0_adv || (r_out_valid && !o_point.ready);
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [tlr_pkg::CFG_DATA_W-1:0] r_screen_w;
    logic [tlr_pkg::CFG_DATA_W-1:0] r_screen_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= tlr_pkg::SCREEN_W_RST;
            r_screen_h <= tlr_pkg::SCREEN_H_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == tlr_pkg::CFG_SCREEN_WIDTH) begin
                r_screen_w <= i_cfg_data;
            end else if (i_cfg_idx == tlr_pkg::CFG_SCREEN_HEIGHT) begin
                r_screen_h <= i_cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input stage: round endpoints and brush, precompute deltas
    // ------------------------------------------------------------------
    logic signed [PW:0] ddx;
    logic signed [PW:0] ddy;

    always_comb begin
        n_s0.opcode = i_line.opcode;
        n_s0.x1     = round_coord(i_line.start_x);
        n_s0.y1     = round_coord(i_line.start_y);
        n_s0.x2     = round_coord(i_line.end_x);
        n_s0.y2     = round_coord(i_line.end_y);
        ddx         = (PW+1)'(n_s0.x2) - (PW+1)'(n_s0.x1);
        ddy         = (PW+1)'(n_s0.y2) - (PW+1)'(n_s0.y1);
        n_s0.step_x_neg = !(ddx > 0);
        n_s0.step_y_neg = !(ddy > 0);
        n_s0.dx     = (ddx < 0) ? tlr_pkg::DELTA_W'(-ddx) : tlr_pkg::DELTA_W'(ddx);
        n_s0.dy_neg = (ddy < 0) ? ddy : -ddy;
        n_s0.stamp  = round_brush(i_line.brush_size);
        n_s0.color  = i_line.pixel_color;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s0 <= n_s0;
        end
    end

    // ------------------------------------------------------------------
    // Line state
    // ------------------------------------------------------------------
    logic                                r_active;
    logic signed [PW-1:0]                r_cur_x, r_cur_y, r_goal_x, r_goal_y;
    logic                                r_step_x_neg, r_step_y_neg;
    logic [tlr_pkg::DELTA_W-1:0]         r_dx;
    logic signed [tlr_pkg::DELTA_W:0]    r_dy_neg;
    logic signed [EW-1:0]                r_err;
    logic [tlr_pkg::STAMP_W-1:0]         r_stamp;
    logic [tlr_pkg::COLOR_W-1:0]         r_color;

    logic                                n_active;
    logic signed [PW-1:0]                n_cur_x, n_cur_y, n_goal_x, n_goal_y;
    logic                                n_step_x_neg, n_step_y_neg;
    logic [tlr_pkg::DELTA_W-1:0]         n_dx;
    logic signed [tlr_pkg::DELTA_W:0]    n_dy_neg;
    logic signed [EW-1:0]                n_err;
    logic [tlr_pkg::STAMP_W-1:0]         n_stamp;
    logic [tlr_pkg::COLOR_W-1:0]         n_color;

    logic signed [EW:0]                  e2;
    logic signed [EW:0]                  dx_ext;
    logic signed [EW:0]                  dyn_ext;
    logic                                take_x, take_y;
    logic                                produced;
    logic                                is_last;

    // Bresenham step or line load
    always_comb begin
        n_active     = r_active;
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_goal_x     = r_goal_x;
        n_goal_y     = r_goal_y;
        n_step_x_neg = r_step_x_neg;
        n_step_y_neg = r_step_y_neg;
        n_dx         = r_dx;
        n_dy_neg     = r_dy_neg;
        n_err        = r_err;
        n_stamp      = r_stamp;
        n_color      = r_color;
        produced     = 1'b0;
        e2           = {r_err, 1'b0};
        dx_ext       = $signed((EW+1)'(r_dx));
        dyn_ext      = (EW+1)'(r_dy_neg);
        take_x       = (e2 >= dyn_ext);
        take_y       = (e2 <= dx_ext);

        if (r_s0.opcode == tlr_pkg::OP_START) begin
            n_cur_x      = r_s0.x1;
            n_cur_y      = r_s0.y1;
            n_goal_x     = r_s0.x2;
            n_goal_y     = r_s0.y2;
            n_step_x_neg = r_s0.step_x_neg;
            n_step_y_neg = r_s0.step_y_neg;
            n_dx         = r_s0.dx;
            n_dy_neg     = r_s0.dy_neg;
            n_err        = EW'(r_s0.dy_neg) + $signed(EW'(r_s0.dx));
            n_stamp      = r_s0.stamp;
            n_color      = r_s0.color;
            n_active     = 1'b1;
            produced     = 1'b1;
        end else if (r_active) begin
            n_err = r_err + (take_x ? EW'(r_dy_neg) : EW'(0))
                          + (take_y ? $signed(EW'(r_dx)) : EW'(0));
            if (take_x) begin
                n_cur_x = r_step_x_neg ? r_cur_x - PW'(1) : r_cur_x + PW'(1);
            end
            if (take_y) begin
                n_cur_y = r_step_y_neg ? r_cur_y - PW'(1) : r_cur_y + PW'(1);
            end
            produced = 1'b1;
        end

        is_last = produced && (n_cur_x == n_goal_x) && (n_cur_y == n_goal_y);
        if (is_last) begin
            n_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (s0_adv) begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_adv) begin
            r_cur_x      <= n_cur_x;
            r_cur_y      <= n_cur_y;
            r_goal_x     <= n_goal_x;
            r_goal_y     <= n_goal_y;
            r_step_x_neg <= n_step_x_neg;
            r_step_y_neg <= n_step_y_neg;
            r_dx         <= n_dx;
            r_dy_neg     <= n_dy_neg;
            r_err        <= n_err;
            r_stamp      <= n_stamp;
            r_color      <= n_color;
        end
    end

    // ------------------------------------------------------------------
    // Stamp placement and clipping
    // ------------------------------------------------------------------
    logic signed [CW-1:0] sw, sh;
    logic signed [CW-1:0] half_t;
    logic signed [CW-1:0] cx, cy, cw, ch;
    logic                 vis;

    always_comb begin
        sw     = (r_screen_w > tlr_pkg::SCREEN_MAX) ? CW'(tlr_pkg::SCREEN_MAX)
                                                    : $signed(CW'(r_screen_w));
        sh     = (r_screen_h > tlr_pkg::SCREEN_MAX) ? CW'(tlr_pkg::SCREEN_MAX)
                                                    : $signed(CW'(r_screen_h));
        half_t = $signed(CW'(n_stamp[tlr_pkg::STAMP_W-1:1]));
        cx     = CW'(n_cur_x) - half_t;
        cy     = CW'(n_cur_y) - half_t;
        cw     = $signed(CW'(n_stamp));
        ch     = $signed(CW'(n_stamp));
        vis    = 1'b1;

        // clip against left and top edges
        if (cx < 0) begin
            cw = cw + cx;
            cx = '0;
        end
        if (cy < 0) begin
            ch = ch + cy;
            cy = '0;
        end

        // right edge; a zero width hides everything
        if (sw == '0 || cx >= sw) begin
            vis = 1'b0;
        end else if (cx + cw > sw) begin
            cw = sw - cx;
        end

        // bottom edge; a zero height means no vertical clip
        if (vis && sh != '0) begin
            if (cy >= sh) begin
                vis = 1'b0;
            end else if (cy + ch > sh) begin
                ch = sh - cy;
            end
        end

        if (cw <= 0 || ch <= 0) begin
            vis = 1'b0;
        end

        // result beat
        n_out = '0;
        if (produced) begin
            n_out.point_valid = 1'b1;
            n_out.visible     = vis;
            n_out.out_color   = n_color;
            n_out.last        = is_last;
            if (vis) begin
                n_out.rect_x = cx[tlr_pkg::RECT_POS_W-1:0];
                n_out.rect_y = cy[tlr_pkg::RECT_POS_W-1:0];
                n_out.rect_w = cw[tlr_pkg::RECT_SIZE_W-1:0];
                n_out.rect_h = ch[tlr_pkg::RECT_SIZE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_adv) begin
            r_out <= n_out;
        end
    end

    // Output channel
    assign o_point.valid       = r_out_valid;
    assign o_point.point_valid = r_out.point_valid;
    assign o_point.visible     = r_out.visible;
    assign o_point.rect_x      = r_out.rect_x;
    assign o_point.rect_y      = r_out.rect_y;
    assign o_point.rect_w      = r_out.rect_w;
    assign o_point.rect_h      = r_out.rect_h;
    assign o_point.out_color   = r_out.out_color;
    assign o_point.last        = r_out.last;

endmodule

### rtl/tlr_checker.sv
// Port-level checks for the thick line rasterizer, bound to the top level.
// Depends on tlr_pkg for field widths; sees only the top level's ports.

module tlr_port_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic                               i_point_valid,
    input logic                               i_visible,
    input logic [tlr_pkg::RECT_POS_W-1:0]     i_rect_x,
    input logic [tlr_pkg::RECT_POS_W-1:0]     i_rect_y,
    input logic [tlr_pkg::RECT_SIZE_W-1:0]    i_rect_w,
    input logic [tlr_pkg::RECT_SIZE_W-1:0]    i_rect_h,
    input logic [tlr_pkg::COLOR_W-1:0]        i_out_color,
    input logic                               i_last
);

    // A stalled point beat stays valid and keeps its rectangle, last and visible flags
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_rect_x)
            && $stable(i_rect_y) && $stable(i_rect_w) && $stable(i_rect_h)
            && $stable(i_last) && $stable(i_visible))
        else $error("point beat changed while stalled");

    // A step with no line gives an all-zero beat
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_point_valid |-> !i_visible && !i_last
            && i_rect_x == '0 && i_rect_y == '0 && i_rect_w == '0
            && i_rect_h == '0 && i_out_color == '0)
        else $error("idle step beat carries data");

    // A hidden stamp has an empty rectangle
    a_hidden_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_point_valid && !i_visible |-> i_rect_x == '0
            && i_rect_y == '0 && i_rect_w == '0 && i_rect_h == '0)
        else $error("hidden stamp has a rectangle");

    // A visible stamp is non-empty and no larger than the largest brush
    a_visible_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_visible |-> i_point_valid && i_rect_w != '0
            && i_rect_h != '0 && i_rect_w <= 9'd256 && i_rect_h <= 9'd256)
        else $error("visible stamp size out of range");

    // Nothing is presented right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("point beat right after reset");

endmodule

bind thick_line_rasterizer tlr_port_checker u_tlr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_point.valid),
    .i_out_ready   (o_point.ready),
    .i_point_valid (o_point.point_valid),
    .i_visible     (o_point.visible),
    .i_rect_x      (o_point.rect_x),
    .i_rect_y      (o_point.rect_y),
    .i_rect_w      (o_point.rect_w),
    .i_rect_h      (o_point.rect_h),
    .i_out_color   (o_point.out_color),
    .i_last        (o_point.last)
);
